// ----- rtl/business_day_counter_macros.svh -----
// Assertion macros shared by the business day counter modules.
`ifndef BUSINESS_DAY_COUNTER_MACROS_SVH
`define BUSINESS_DAY_COUNTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BDC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bdc_pkg.sv -----
// Types, constants and calendar tables for the business day counter.
`default_nettype none
package bdc_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;
	localparam int DSUM_W  = 15;

	localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [2:0]         DOW_SAT   = 3'd5;
	localparam logic [2:0]         DOW_SUN   = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUOT_START,
		ST_QUOT_END,
		ST_PREP,
		ST_REDUCE,
		ST_WALK,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic load;
		logic quot_start;
		logic quot_end;
		logic prep;
		logic reduce;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic later;
		logic at_end;
	} status_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd2:                     n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
			default:                  n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/bdc_datapath.sv -----
// Datapath: date setup, weekday of the start date, and the day-by-day calendar walk.
`default_nettype none
`include "business_day_counter_macros.svh"
module bdc_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bdc_pkg::cmd_t                   cmd,
	output bdc_pkg::status_t                     status,
	input  wire logic [bdc_pkg::YEAR_W-1:0]      start_year,
	input  wire logic [bdc_pkg::MONTH_W-1:0]     start_month,
	input  wire logic [bdc_pkg::DAY_W-1:0]       start_day,
	input  wire logic [bdc_pkg::YEAR_W-1:0]      end_year,
	input  wire logic [bdc_pkg::MONTH_W-1:0]     end_month,
	input  wire logic [bdc_pkg::DAY_W-1:0]       end_day,
	output logic [bdc_pkg::COUNT_W-1:0]          weekday_count
);

	localparam logic [25:0] RECIP_100 = 26'd5243;
	localparam logic [30:0] RECIP_7   = 31'd37450;

	logic [bdc_pkg::YEAR_W-1:0]  sy_q, ey_q, cy_q;
	logic [bdc_pkg::MONTH_W-1:0] sm_q, em_q, cm_q;
	logic [bdc_pkg::DAY_W-1:0]   sdr_q, edr_q, ed_q, cd_q;
	logic [6:0]                  sq100_q, eq100_q;
	logic [1:0]                  r4_q;
	logic [6:0]                  r100_q;
	logic [8:0]                  r400_q;
	logic [bdc_pkg::DSUM_W-1:0]  dsum_q;
	logic [2:0]                  dow_q;
	logic                        later_q;
	logic [bdc_pkg::COUNT_W-1:0] count_q, out_q;

	logic [bdc_pkg::YEAR_W-1:0]  sy_c, ey_c;
	logic [bdc_pkg::MONTH_W-1:0] sm_c, em_c;
	logic [bdc_pkg::YEAR_W-1:0]  mul_in;
	logic [25:0]                 prod100;
	logic [6:0]                  quot100;

	logic [13:0]                 s_hund, s_quad, e_hund, e_quad, py;
	logic [6:0]                  s_rem100, e_rem100, pyq100;
	logic [8:0]                  s_rem400, e_rem400;
	logic                        s_leap, e_leap;
	logic [bdc_pkg::DAY_W-1:0]   s_mdays, e_mdays, sd_c, ed_c;
	logic [bdc_pkg::DSUM_W-1:0]  dsum;

	logic [30:0]                 prod7;
	logic [12:0]                 quot7;
	logic [2:0]                  rem7;

	logic                        c_leap;
	logic [bdc_pkg::DAY_W-1:0]   c_mdays;
	logic [2:0]                  dow_next;

	always_comb begin
		sy_c = start_year;
		if (start_year < bdc_pkg::YEAR_MIN) sy_c = bdc_pkg::YEAR_MIN;
		if (start_year > bdc_pkg::YEAR_MAX) sy_c = bdc_pkg::YEAR_MAX;
		ey_c = end_year;
		if (end_year < bdc_pkg::YEAR_MIN) ey_c = bdc_pkg::YEAR_MIN;
		if (end_year > bdc_pkg::YEAR_MAX) ey_c = bdc_pkg::YEAR_MAX;
		sm_c = start_month;
		if (start_month < bdc_pkg::MONTH_JAN) sm_c = bdc_pkg::MONTH_JAN;
		if (start_month > bdc_pkg::MONTH_DEC) sm_c = bdc_pkg::MONTH_DEC;
		em_c = end_month;
		if (end_month < bdc_pkg::MONTH_JAN) em_c = bdc_pkg::MONTH_JAN;
		if (end_month > bdc_pkg::MONTH_DEC) em_c = bdc_pkg::MONTH_DEC;
	end

	// Shared divide-by-100 unit: reciprocal multiply, exact for years below 10000.
	assign mul_in  = cmd.quot_end ? ey_q : sy_q;
	assign prod100 = {12'd0, mul_in} * RECIP_100;
	assign quot100 = prod100[25:19];

	always_comb begin
		s_hund   = {7'd0, sq100_q} * 14'd100;
		s_rem100 = 7'(sy_q - s_hund);
		s_quad   = {9'd0, sq100_q[6:2]} * 14'd400;
		s_rem400 = 9'(sy_q - s_quad);
		s_leap   = (sy_q[1:0] == 2'd0 && s_rem100 != 7'd0) || s_rem400 == 9'd0;
		e_hund   = {7'd0, eq100_q} * 14'd100;
		e_rem100 = 7'(ey_q - e_hund);
		e_quad   = {9'd0, eq100_q[6:2]} * 14'd400;
		e_rem400 = 9'(ey_q - e_quad);
		e_leap   = (ey_q[1:0] == 2'd0 && e_rem100 != 7'd0) || e_rem400 == 9'd0;

		s_mdays = bdc_pkg::month_days(sm_q, s_leap);
		e_mdays = bdc_pkg::month_days(em_q, e_leap);
		if (sdr_q == 5'd0)         sd_c = 5'd1;
		else if (sdr_q > s_mdays)  sd_c = s_mdays;
		else                       sd_c = sdr_q;
		if (edr_q == 5'd0)         ed_c = 5'd1;
		else if (edr_q > e_mdays)  ed_c = e_mdays;
		else                       ed_c = edr_q;

		// Day number of the start date reduced mod 7 later; 365 is 1 mod 7.
		py     = sy_q - 14'd1;
		pyq100 = sq100_q - 7'(s_rem100 == 7'd0);
		dsum   = 15'(py) + 15'(py[13:2]) - 15'(pyq100) + 15'(pyq100[6:2])
			+ 15'(bdc_pkg::days_before(sm_q))
			+ 15'(sm_q > bdc_pkg::MONTH_FEB && s_leap) + 15'(sd_c) - 15'd1;
	end

	assign prod7 = {16'd0, dsum_q} * RECIP_7;
	assign quot7 = prod7[30:18];
	assign rem7  = 3'(dsum_q - {2'd0, quot7} * 15'd7);

	assign c_leap   = (r4_q == 2'd0 && r100_q != 7'd0) || r400_q == 9'd0;
	assign c_mdays  = bdc_pkg::month_days(cm_q, c_leap);
	assign dow_next = (dow_q == bdc_pkg::DOW_SUN) ? 3'd0 : dow_q + 3'd1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sy_q  <= sy_c;
			sm_q  <= sm_c;
			sdr_q <= start_day;
			ey_q  <= ey_c;
			em_q  <= em_c;
			edr_q <= end_day;
		end
		if (cmd.quot_start) sq100_q <= quot100;
		if (cmd.quot_end)   eq100_q <= quot100;
		if (cmd.prep) begin
			ed_q    <= ed_c;
			cy_q    <= sy_q;
			cm_q    <= sm_q;
			cd_q    <= sd_c;
			r4_q    <= sy_q[1:0];
			r100_q  <= s_rem100;
			r400_q  <= s_rem400;
			dsum_q  <= dsum;
			later_q <= {ey_q, em_q, ed_c} > {sy_q, sm_q, sd_c};
		end
		if (cmd.reduce) begin
			dow_q   <= rem7;
			count_q <= '0;
		end
		if (cmd.step) begin
			dow_q <= dow_next;
			if (dow_next < bdc_pkg::DOW_SAT) count_q <= count_q + 22'd1;
			if (cd_q == c_mdays) begin
				cd_q <= 5'd1;
				if (cm_q == bdc_pkg::MONTH_DEC) begin
					cm_q   <= bdc_pkg::MONTH_JAN;
					cy_q   <= cy_q + 14'd1;
					r4_q   <= r4_q + 2'd1;
					r100_q <= (r100_q == 7'd99) ? 7'd0 : r100_q + 7'd1;
					r400_q <= (r400_q == 9'd399) ? 9'd0 : r400_q + 9'd1;
				end else begin
					cm_q <= cm_q + 4'd1;
				end
			end else begin
				cd_q <= cd_q + 5'd1;
			end
		end
		if (cmd.load_out) out_q <= count_q;
	end

	assign status.later  = later_q;
	assign status.at_end = cy_q == ey_q && cm_q == em_q && cd_q == ed_q;
	assign weekday_count = out_q;

	`BDC_ASSERT_NEXT(a_count_step, cmd.step, count_q == $past(count_q) || count_q == $past(count_q) + 22'd1, "count moved by more than one day")
	`BDC_ASSERT_SAME(a_walk_date_ok, cmd.step, cd_q != 5'd0 && cd_q <= c_mdays && cm_q != 4'd0 && cm_q <= bdc_pkg::MONTH_DEC, "walk reached an invalid date")
	`BDC_ASSERT_SAME(a_walk_dow_ok, cmd.step, dow_q != 3'd7, "weekday out of range during walk")

endmodule
`default_nettype wire

// ----- rtl/bdc_ctrl.sv -----
// Controller: sequences setup, walk and result hand-off, and holds the output valid.
`default_nettype none
`include "business_day_counter_macros.svh"
module bdc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output bdc_pkg::cmd_t          cmd,
	input  wire bdc_pkg::status_t  status
);

	bdc_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			bdc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bdc_pkg::ST_QUOT_START;
				end
			end
			bdc_pkg::ST_QUOT_START: begin
				cmd.quot_start = 1'b1;
				state_d        = bdc_pkg::ST_QUOT_END;
			end
			bdc_pkg::ST_QUOT_END: begin
				cmd.quot_end = 1'b1;
				state_d      = bdc_pkg::ST_PREP;
			end
			bdc_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = bdc_pkg::ST_REDUCE;
			end
			bdc_pkg::ST_REDUCE: begin
				cmd.reduce = 1'b1;
				state_d    = status.later ? bdc_pkg::ST_WALK : bdc_pkg::ST_OUTPUT;
			end
			bdc_pkg::ST_WALK: begin
				if (status.at_end) state_d = bdc_pkg::ST_OUTPUT;
				else cmd.step = 1'b1;
			end
			bdc_pkg::ST_OUTPUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = bdc_pkg::ST_IDLE;
				end
			end
			default: state_d = bdc_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`BDC_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_q == bdc_pkg::ST_QUOT_START, "accepted item did not start setup")
	`BDC_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid_q || !out_stall, "result overwrote a pending result")
	`BDC_ASSERT_NEXT(a_walk_ends, state_q == bdc_pkg::ST_WALK && status.at_end, state_q == bdc_pkg::ST_OUTPUT && !cmd.step, "walk did not stop at the end date")

endmodule
`default_nettype wire

// ----- rtl/business_day_counter.sv -----
// Top level of the business day counter: controller and datapath.
//
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid / in_stall     start_year, start_month, start_day,
//                                               end_year, end_month, end_day
//  out       output     out_valid / out_stall   weekday_count
//
// Setup passes through the accepting cycle, two divide-by-100 steps, date preparation and the
// weekday reduction. The walk then advances one calendar day per cycle and stops in the cycle that
// sees the end date; the count is then moved into the output register once out_stall no longer
// holds an earlier result. A new item is taken only after that move; an end not after the start
// skips the walk.
// Reset clears the state machine and the output valid; no memory needs clearing.
// A result held by out_stall stays in the output register while the next item is worked on.
`default_nettype none
module business_day_counter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [bdc_pkg::YEAR_W-1:0]   start_year,
	input  wire logic [bdc_pkg::MONTH_W-1:0]  start_month,
	input  wire logic [bdc_pkg::DAY_W-1:0]    start_day,
	input  wire logic [bdc_pkg::YEAR_W-1:0]   end_year,
	input  wire logic [bdc_pkg::MONTH_W-1:0]  end_month,
	input  wire logic [bdc_pkg::DAY_W-1:0]    end_day,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [bdc_pkg::COUNT_W-1:0]       weekday_count
);

	bdc_pkg::cmd_t    cmd;
	bdc_pkg::status_t status;

	bdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	bdc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.start_year    (start_year),
		.start_month   (start_month),
		.start_day     (start_day),
		.end_year      (end_year),
		.end_month     (end_month),
		.end_day       (end_day),
		.weekday_count (weekday_count)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb_business_day_counter.sv -----
// Testbench for the business day counter: directed and random date spans checked against a predictor.
`default_nettype none
module tb_business_day_counter;

	localparam int NUM_DIRECTED = 18;
	localparam int NUM_RANDOM   = 400;
	localparam int IDLE_LIMIT   = 200000;
	localparam int END_WAIT     = 40;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 4000;

	typedef logic [bdc_pkg::YEAR_W-1:0]  year_t;
	typedef logic [bdc_pkg::MONTH_W-1:0] month_t;
	typedef logic [bdc_pkg::DAY_W-1:0]   day_t;
	typedef logic [bdc_pkg::COUNT_W-1:0] count_t;

	typedef struct packed {
		year_t  sy;
		month_t sm;
		day_t   sd;
		year_t  ey;
		month_t em;
		day_t   ed;
	} date_span_t;

	typedef struct packed {
		date_span_t span;
		logic       known;
		count_t     count;
	} span_row_t;

	// Rows with known set carry a count that can be read off the calendar directly.
	localparam span_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{'{14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd2}, 1'b1, 22'd1},
		'{'{14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd1}, 1'b1, 22'd0},
		'{'{14'd2, 4'd1, 5'd1, 14'd1, 4'd12, 5'd31}, 1'b1, 22'd0},
		'{'{14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd7}, 1'b1, 22'd4},
		'{'{14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd8}, 1'b1, 22'd5},
		'{'{14'd0, 4'd0, 5'd0, 14'd1, 4'd1, 5'd2}, 1'b1, 22'd1},
		'{'{14'd16383, 4'd15, 5'd31, 14'd9999, 4'd12, 5'd31}, 1'b1, 22'd0},
		'{'{14'd1, 4'd1, 5'd2, 14'd0, 4'd0, 5'd0}, 1'b1, 22'd0},
		'{'{14'd2020, 4'd13, 5'd31, 14'd2020, 4'd12, 5'd31}, 1'b1, 22'd0},
		'{'{14'd9999, 4'd12, 5'd30, 14'd9999, 4'd12, 5'd31}, 1'b0, 22'd0},
		'{'{14'd9998, 4'd12, 5'd25, 14'd16383, 4'd15, 5'd31}, 1'b0, 22'd0},
		'{'{14'd2023, 4'd2, 5'd31, 14'd2023, 4'd3, 5'd1}, 1'b0, 22'd0},
		'{'{14'd2024, 4'd2, 5'd30, 14'd2024, 4'd3, 5'd1}, 1'b0, 22'd0},
		'{'{14'd1900, 4'd2, 5'd29, 14'd1900, 4'd3, 5'd1}, 1'b0, 22'd0},
		'{'{14'd2000, 4'd2, 5'd29, 14'd2000, 4'd3, 5'd1}, 1'b0, 22'd0},
		'{'{14'd2023, 4'd4, 5'd30, 14'd2023, 4'd5, 5'd2}, 1'b0, 22'd0},
		'{'{14'd2023, 4'd12, 5'd31, 14'd2024, 4'd1, 5'd1}, 1'b0, 22'd0},
		'{'{14'd1900, 4'd1, 5'd1, 14'd2000, 4'd1, 5'd1}, 1'b0, 22'd0}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	year_t   start_year = '0;
	month_t  start_month = '0;
	day_t    start_day = '0;
	year_t   end_year = '0;
	month_t  end_month = '0;
	day_t    end_day = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	count_t  weekday_count;

	count_t  pending_counts [$];
	int      mismatch_count = 0;
	int      results_seen = 0;

	business_day_counter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_year    (start_year),
		.start_month   (start_month),
		.start_day     (start_day),
		.end_year      (end_year),
		.end_month     (end_month),
		.end_day       (end_day),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.weekday_count (weekday_count)
	);

	initial begin
		forever begin
			#6 clk = ~clk;
		end
	end

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		case (m)
			2: begin
				return leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	// Days since 0001-01-01 after out-of-range fields are pulled into the calendar.
	function automatic int unsigned serial_day(input year_t yf, input month_t mf,
		input day_t df);
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned py;
		int unsigned n;
		int unsigned k;
		y = 32'(yf);
		m = 32'(mf);
		d = 32'(df);
		if (y < 32'(bdc_pkg::YEAR_MIN)) y = 32'(bdc_pkg::YEAR_MIN);
		if (y > 32'(bdc_pkg::YEAR_MAX)) y = 32'(bdc_pkg::YEAR_MAX);
		if (m < 32'(bdc_pkg::MONTH_JAN)) m = 32'(bdc_pkg::MONTH_JAN);
		if (m > 32'(bdc_pkg::MONTH_DEC)) m = 32'(bdc_pkg::MONTH_DEC);
		if (d < 1) d = 1;
		if (d > days_in_month(y, m)) d = days_in_month(y, m);
		py = y - 1;
		n = 365 * py + py / 4 - py / 100 + py / 400;
		for (k = 1; k < m; k++) begin
			n += days_in_month(y, k);
		end
		return n + d - 1;
	endfunction

	function automatic int unsigned weekdays_upto(input int unsigned n);
		int unsigned t;
		int unsigned r;
		t = n + 1;
		r = t % 7;
		return (t / 7) * 5 + ((r < 5) ? r : 5);
	endfunction

	function automatic count_t business_days(input date_span_t s);
		int unsigned first;
		int unsigned last;
		int unsigned diff;
		first = serial_day(s.sy, s.sm, s.sd);
		last = serial_day(s.ey, s.em, s.ed);
		diff = 0;
		if (last > first) begin
			diff = weekdays_upto(last) - weekdays_upto(first);
		end
		return diff[bdc_pkg::COUNT_W-1:0];
	endfunction

	function automatic date_span_t random_span(input bit long_span);
		date_span_t s;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		s.sy = year_t'($urandom_range(1, 9999));
		s.sm = month_t'($urandom_range(1, 12));
		s.sd = day_t'($urandom_range(1, 31));
		s.em = month_t'($urandom_range(1, 12));
		s.ed = day_t'($urandom_range(1, 31));
		s.ey = year_t'(s.sy + (($urandom_range(0, 2) == 0) ? 1 : 0));
		if (long_span) begin
			s.sy = year_t'($urandom_range(1, 9900));
			s.ey = year_t'(s.sy + $urandom_range(20, 40));
		end else if (kind < 15) begin
			s.sy = year_t'($urandom);
			s.sm = month_t'($urandom);
			s.sd = day_t'($urandom);
			s.ey = year_t'(s.sy + $urandom_range(0, 1));
			s.em = month_t'($urandom);
			s.ed = day_t'($urandom);
		end else if (kind < 25) begin
			s.sy = year_t'($urandom_range(9998, 16383));
			s.ey = year_t'($urandom_range(9998, 16383));
		end else if (kind < 35) begin
			s.ey = year_t'(s.sy - $urandom_range(0, 1));
		end
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		mismatch_count++;
	endtask

	task automatic send_span(input date_span_t s, input count_t expected);
		start_year  <= s.sy;
		start_month <= s.sm;
		start_day   <= s.sd;
		end_year    <= s.ey;
		end_month   <= s.em;
		end_day     <= s.ed;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_counts = {pending_counts, expected};
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_counts.size() != 0);
	endtask

	initial begin : stimulus
		span_row_t  row;
		date_span_t s;
		int         n;
		int         burst;
		int         gap;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (n = 0; n < NUM_DIRECTED; n++) begin
			row = DIRECTED_ROWS[n];
			send_span(row.span, row.known ? row.count : business_days(row.span));
		end
		drain_results();
		burst = $urandom_range(1, 30);
		for (n = 0; n < NUM_RANDOM; n++) begin
			s = random_span(n == 120 || n == 300);
			send_span(s, business_days(s));
			if (n == NUM_RANDOM / 2) begin
				drain_results();
			end else begin
				burst--;
				if (burst == 0) begin
					burst = $urandom_range(1, 30);
					gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 8);
					if (gap > 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
		end
		drain_results();
		repeat (END_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : result_side
		count_t expected;
		int     mode;
		int     mode_left;
		int     hold;
		bit     held;
		bit     stall_next;
		mode = 0;
		mode_left = 0;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_counts.size() == 0) begin
					report_mismatch($sformatf("result %0d with no item pending", weekday_count));
				end else begin
					expected = pending_counts.pop_front();
					if (weekday_count !== expected) begin
						report_mismatch($sformatf("weekday_count got %0d expected %0d",
							weekday_count, expected));
					end
				end
			end
			if (results_seen == HOLD_AT && !held) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(1, 150);
			end
			mode_left--;
			case (mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 3) == 0);
				default: stall_next = ($urandom_range(0, 3) != 0);
			endcase
			if (hold > 0) begin
				hold--;
				stall_next = 1'b1;
			end
			out_stall <= stall_next;
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
